// File: sv/per_flow_packet_loss_counter_top_defines.svh
// Assertion macros shared by the packet loss counter modules.
`ifndef PER_FLOW_PACKET_LOSS_COUNTER_TOP_DEFINES_SVH
`define PER_FLOW_PACKET_LOSS_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define PLFC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define PLFC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/plfc_pkg.sv
// Shared types and constants of the per-flow packet loss counter.
package plfc_pkg;

	localparam int unsigned MAX_BOARDS_DEF = 16;
	localparam int unsigned MODE_SLOTS_DEF = 8;
	localparam int unsigned QUEUE_DEPTH    = 4;

	localparam int unsigned MODE_W     = 8;
	localparam int unsigned NUM_W      = 16;
	localparam int unsigned BOARD_W    = 16;
	localparam int unsigned SLOT_OUT_W = 4;
	localparam int unsigned NOW_W      = 17;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned STATUS_W   = 2;

	localparam logic [NOW_W-1:0] WRAP_TOP = 17'h0ffff;

	typedef enum logic [STATUS_W-1:0] {
		ST_KNOWN    = 2'd0,
		ST_NEW      = 2'd1,
		ST_FULL     = 2'd2,
		ST_BAD_MODE = 2'd3
	} status_t;

endpackage

// File: sv/per_flow_packet_loss_counter_top.sv
// Top level of the per-flow packet loss counter: front end, item queue and back end.
// An accepted item passes the queue, the back-end stage register and the output register.
// One item per cycle unless out_stall; flow store read each item, written for known/new items.
// Items reach the back end through a four-entry queue, so the input runs on while results wait.
// Reset clears the board fill count, the queue, the pipeline valid flags and the grand total.
// Board, flow and seen-mask stores need no clearing; a new board masks its stale entries.
module per_flow_packet_loss_counter_top import plfc_pkg::*; #(
	parameter int unsigned MAX_BOARDS = MAX_BOARDS_DEF,
	parameter int unsigned MODE_SLOTS = MODE_SLOTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [MODE_W-1:0]       mode_byte,
	input  logic [NUM_W-1:0]        packet_number,
	input  logic [BOARD_W-1:0]      board_id,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [SLOT_OUT_W-1:0]   slot_index,
	output logic [STATUS_W-1:0]     status_code,
	output logic signed [NOW_W-1:0] lost_now,
	output logic signed [CNT_W-1:0] flow_lost_count,
	output logic signed [CNT_W-1:0] total_lost_count
);

	localparam int unsigned SLOT_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
	localparam int unsigned MIDX_W = $clog2(MODE_SLOTS);
	localparam int unsigned FLOW_W = $clog2(MAX_BOARDS * MODE_SLOTS);
	localparam int unsigned ITEM_W = SLOT_W + MIDX_W + FLOW_W + NUM_W + STATUS_W;

	// The front end classifies an item in the cycle it is accepted and pushes it to the queue.
	logic              accept;
	logic [SLOT_W-1:0] f_slot;
	logic [MIDX_W-1:0] f_mode;
	logic [FLOW_W-1:0] f_flow;
	status_t           f_status;

	// Queue head as seen by the back end.
	logic [ITEM_W-1:0] push_data;
	logic [ITEM_W-1:0] pop_data;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic [SLOT_W-1:0] q_slot;
	logic [MIDX_W-1:0] q_mode;
	logic [FLOW_W-1:0] q_flow;
	logic [NUM_W-1:0]  q_num;
	logic [STATUS_W-1:0] q_status_bits;

	// The input stalls only when the queue is full; that depends on registers alone.
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	plfc_front #(
		.MAX_BOARDS (MAX_BOARDS),
		.MODE_SLOTS (MODE_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mode_byte (mode_byte),
		.board_id  (board_id),
		.slot      (f_slot),
		.mode_idx  (f_mode),
		.flow      (f_flow),
		.status    (f_status)
	);

	assign push_data = {f_slot, f_mode, f_flow, packet_number, f_status};

	plfc_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.not_empty (q_valid)
	);

	assign {q_slot, q_mode, q_flow, q_num, q_status_bits} = pop_data;

	// The back end owns the flow state and the grand total, and holds the output register.
	plfc_back #(
		.MAX_BOARDS (MAX_BOARDS),
		.MODE_SLOTS (MODE_SLOTS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_slot           (q_slot),
		.q_mode           (q_mode),
		.q_flow           (q_flow),
		.q_num            (q_num),
		.q_status         (status_t'(q_status_bits)),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.slot_index       (slot_index),
		.status_code      (status_code),
		.lost_now         (lost_now),
		.flow_lost_count  (flow_lost_count),
		.total_lost_count (total_lost_count)
	);

endmodule

// File: sv/plfc_front.sv
// Front end: board table lookup, slot allocation and item classification.
module plfc_front import plfc_pkg::*; #(
	parameter int unsigned MAX_BOARDS = MAX_BOARDS_DEF,
	parameter int unsigned MODE_SLOTS = MODE_SLOTS_DEF,
	localparam int unsigned SLOT_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1,
	localparam int unsigned MIDX_W = $clog2(MODE_SLOTS),
	localparam int unsigned FLOW_W = $clog2(MAX_BOARDS * MODE_SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [MODE_W-1:0]   mode_byte,
	input  logic [BOARD_W-1:0]  board_id,
	output logic [SLOT_W-1:0]   slot,
	output logic [MIDX_W-1:0]   mode_idx,
	output logic [FLOW_W-1:0]   flow,
	output status_t             status
);

	localparam int unsigned USED_W = $clog2(MAX_BOARDS + 1);

	logic [BOARD_W-1:0] table_q [MAX_BOARDS];
	logic [USED_W-1:0]  used_q;
	logic               hit;
	logic [SLOT_W-1:0]  hit_slot;
	logic               mode_bad;
	logic               full;
	logic               alloc;

	// Valid entries are filled in order, so an entry is live when below the fill count.
	// At most one live entry can match, so the slot number is an OR of the hits.
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = 0; i < int'(MAX_BOARDS); i++) begin
			if ((USED_W'(i) < used_q) && (table_q[i] == board_id)) begin
				hit      = 1'b1;
				hit_slot = hit_slot | SLOT_W'(i);
			end
		end
	end

	assign mode_bad = mode_byte >= MODE_W'(MODE_SLOTS);
	assign full     = used_q == USED_W'(MAX_BOARDS);

	always_comb begin
		status   = ST_KNOWN;
		slot     = '0;
		mode_idx = '0;
		if (mode_bad) begin
			status = ST_BAD_MODE;
		end else if (hit) begin
			status   = ST_KNOWN;
			slot     = hit_slot;
			mode_idx = mode_byte[MIDX_W-1:0];
		end else if (full) begin
			status = ST_FULL;
		end else begin
			status   = ST_NEW;
			slot     = used_q[SLOT_W-1:0];
			mode_idx = mode_byte[MIDX_W-1:0];
		end
	end

	assign flow  = FLOW_W'(slot) * FLOW_W'(MODE_SLOTS) + FLOW_W'(mode_idx);
	assign alloc = accept && (status == ST_NEW);

	always_ff @(posedge clk) begin
		if (alloc) begin
			table_q[used_q[SLOT_W-1:0]] <= board_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (alloc) begin
			used_q <= used_q + USED_W'(1);
		end
	end

endmodule

// File: sv/plfc_queue.sv
// Short item queue between the front end and the flow update back end.
`include "per_flow_packet_loss_counter_top_defines.svh"
module plfc_queue import plfc_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]   store_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;

	assign full      = count_q == CNT_W_Q'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W_Q'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W_Q'(1);
			end
		end
	end

	`PLFC_ASSERT_IMP(a_no_push_full, full, !push, "queue pushed while full")
	`PLFC_ASSERT_IMP(a_no_pop_empty, pop, not_empty, "queue popped while empty")
	`PLFC_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W_Q'(DEPTH), "queue count overflow")

endmodule

// File: sv/plfc_back.sv
// Back end: per-flow state read, gap computation, saturating counters and output register.
`include "per_flow_packet_loss_counter_top_defines.svh"
module plfc_back import plfc_pkg::*; #(
	parameter int unsigned MAX_BOARDS = MAX_BOARDS_DEF,
	parameter int unsigned MODE_SLOTS = MODE_SLOTS_DEF,
	localparam int unsigned SLOT_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1,
	localparam int unsigned MIDX_W = $clog2(MODE_SLOTS),
	localparam int unsigned FLOW_W = $clog2(MAX_BOARDS * MODE_SLOTS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  logic [SLOT_W-1:0]       q_slot,
	input  logic [MIDX_W-1:0]       q_mode,
	input  logic [FLOW_W-1:0]       q_flow,
	input  logic [NUM_W-1:0]        q_num,
	input  status_t                 q_status,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [SLOT_OUT_W-1:0]   slot_index,
	output logic [STATUS_W-1:0]     status_code,
	output logic signed [NOW_W-1:0] lost_now,
	output logic signed [CNT_W-1:0] flow_lost_count,
	output logic signed [CNT_W-1:0] total_lost_count
);

	localparam int unsigned FLOWS   = MAX_BOARDS * MODE_SLOTS;
	localparam int unsigned ENTRY_W = CNT_W + NUM_W;
	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W - 1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W - 1){1'b0}}};

	function automatic logic signed [CNT_W-1:0] sat_add(
		input logic signed [CNT_W-1:0] a,
		input logic signed [NOW_W-1:0] b
	);
		logic signed [CNT_W:0] s;
		s = {a[CNT_W-1], a} + {{(CNT_W + 1 - NOW_W){b[NOW_W-1]}}, b};
		if (s[CNT_W] != s[CNT_W-1]) begin
			return s[CNT_W] ? CNT_MIN : CNT_MAX;
		end
		return s[CNT_W-1:0];
	endfunction

	logic [ENTRY_W-1:0]    flow_mem [FLOWS];
	logic [MODE_SLOTS-1:0] mask_mem [MAX_BOARDS];
	logic [ENTRY_W-1:0]    flow_rd_q;
	logic [MODE_SLOTS-1:0] mask_rd_q;

	logic                  valid_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic [MIDX_W-1:0]     mode_s1;
	logic [FLOW_W-1:0]     flow_s1;
	logic [NUM_W-1:0]      num_s1;
	status_t               status_s1;
	logic                  flow_hit_s1;
	logic [ENTRY_W-1:0]    flow_fwd_s1;
	logic                  mask_hit_s1;
	logic [MODE_SLOTS-1:0] mask_fwd_s1;

	logic signed [CNT_W-1:0] grand_q;
	logic                    out_valid_q;
	logic [SLOT_OUT_W-1:0]   slot_q;
	logic [STATUS_W-1:0]     status_q;
	logic signed [NOW_W-1:0] now_q;
	logic signed [CNT_W-1:0] flow_cnt_q;
	logic signed [CNT_W-1:0] total_q;

	logic                    active;
	logic                    commit;
	logic                    ld;
	logic [ENTRY_W-1:0]      entry;
	logic [NUM_W-1:0]        prev;
	logic signed [CNT_W-1:0] lost_old;
	logic [MODE_SLOTS-1:0]   mask_old;
	logic [MODE_SLOTS-1:0]   mode_bit;
	logic                    seen;
	logic [NOW_W-1:0]        diff;
	logic [NOW_W-1:0]        gap;
	logic signed [NOW_W-1:0] now;
	logic signed [CNT_W-1:0] flow_new;
	logic signed [CNT_W-1:0] grand_new;
	logic [ENTRY_W-1:0]      wr_entry;
	logic [MODE_SLOTS-1:0]   wr_mask;

	assign active = valid_s1 && ((status_s1 == ST_KNOWN) || (status_s1 == ST_NEW));
	assign commit = valid_s1 && (!out_valid_q || !out_stall);
	assign ld     = q_valid && (!valid_s1 || commit);
	assign q_pop  = ld;

	// A freshly allocated board has no flow seen yet, whatever its mask entry holds.
	assign entry    = flow_hit_s1 ? flow_fwd_s1 : flow_rd_q;
	assign prev     = entry[NUM_W-1:0];
	assign lost_old = entry[ENTRY_W-1:NUM_W];
	assign mask_old = (status_s1 == ST_NEW) ? '0 : (mask_hit_s1 ? mask_fwd_s1 : mask_rd_q);
	assign mode_bit = MODE_SLOTS'(1) << mode_s1;
	assign seen     = |(mask_old & mode_bit);

	// Gap in 17-bit modular arithmetic; the wrapped case lands in 0 .. 0xfffe.
	assign diff      = {1'b0, num_s1} - {1'b0, prev};
	assign gap       = (num_s1 < prev) ? (diff + WRAP_TOP) : (diff - NOW_W'(1));
	assign now       = (active && seen) ? $signed(gap) : '0;
	assign flow_new  = seen ? sat_add(lost_old, now) : '0;
	assign grand_new = (active && seen) ? sat_add(grand_q, now) : grand_q;
	assign wr_entry  = {flow_new, num_s1};
	assign wr_mask   = mask_old | mode_bit;

	// Read-before-write memories; the value written at the load edge is forwarded.
	always_ff @(posedge clk) begin
		if (commit && active) begin
			flow_mem[flow_s1] <= wr_entry;
			mask_mem[slot_s1] <= wr_mask;
		end
		if (ld) begin
			flow_rd_q <= flow_mem[q_flow];
			mask_rd_q <= mask_mem[q_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			slot_s1     <= q_slot;
			mode_s1     <= q_mode;
			flow_s1     <= q_flow;
			num_s1      <= q_num;
			status_s1   <= q_status;
			flow_hit_s1 <= commit && active && (flow_s1 == q_flow);
			flow_fwd_s1 <= wr_entry;
			mask_hit_s1 <= commit && active && (slot_s1 == q_slot);
			mask_fwd_s1 <= wr_mask;
		end
		if (commit) begin
			slot_q     <= SLOT_OUT_W'(slot_s1);
			status_q   <= status_s1;
			now_q      <= now;
			flow_cnt_q <= active ? flow_new : '0;
			total_q    <= grand_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			grand_q     <= '0;
		end else begin
			if (ld) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			out_valid_q <= commit || (out_valid_q && out_stall);
			if (commit) begin
				grand_q <= grand_new;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign slot_index       = slot_q;
	assign status_code      = status_q;
	assign lost_now         = now_q;
	assign flow_lost_count  = flow_cnt_q;
	assign total_lost_count = total_q;

	`PLFC_ASSERT_NXT(a_ignored_zero, commit && !active, out_valid_q && (slot_q == '0) && (now_q == '0) && (flow_cnt_q == '0), "ignored item produced nonzero fields")
	`PLFC_ASSERT_NXT(a_grand_hold, !(commit && active), $stable(grand_q), "grand total moved without a flow update")
	`PLFC_ASSERT_IMP(a_dup_minus_one, commit && (now == '1), seen && (num_s1 == prev), "loss of -1 without a repeated number")

endmodule
